// File: rtl/core/sams_pkg.sv
package sams_pkg;

    localparam int VERTEX_IDX_W = 6;
    localparam int WEIGHT_PORT_W = 16;
    localparam int COUNT_PORT_W = 7;
    localparam int EDGE_PORT_W = 12;

    localparam logic [COUNT_PORT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ = 1'b1;

endpackage

// File: rtl/core/sams_ram.sv
module sams_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/symmetric_adjacency_matrix_store.sv
// Channel   Direction  Handshake                    Payload
// item      in         item_valid / item_ready      op, first_vertex, second_vertex, weight
// result    out        result_valid / result_ready  found_weight .. bad_index
// cfg       in         cfg_valid / cfg_ready        vertex_count
//
// After reset a clearing pass zeroes the matrix, one cell per cycle, all MAX_VERTICES *
// MAX_VERTICES cells (4096 by default); items wait, cfg transfers do not.
// A valid item steps through read, update of the first cell and degree, update of the
// mirrored cell and second degree, and result load, on memories with separate read and write
// ports. A bad-index item skips to the result load. A result waits in its output register, and
// the next item is taken while it waits; only the result load stalls on a full register.
module symmetric_adjacency_matrix_store #(
    parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [sams_pkg::COUNT_PORT_W-1:0]        vertex_count,
    input  logic                                     item_valid,
    output logic                                     item_ready,
    input  logic                                     op,
    input  logic [sams_pkg::VERTEX_IDX_W-1:0]        first_vertex,
    input  logic [sams_pkg::VERTEX_IDX_W-1:0]        second_vertex,
    input  logic signed [sams_pkg::WEIGHT_PORT_W-1:0] weight,
    output logic                                     result_valid,
    input  logic                                     result_ready,
    output logic signed [sams_pkg::WEIGHT_PORT_W-1:0] found_weight,
    output logic [sams_pkg::COUNT_PORT_W-1:0]        first_degree,
    output logic [sams_pkg::COUNT_PORT_W-1:0]        second_degree,
    output logic [sams_pkg::EDGE_PORT_W-1:0]         edge_total,
    output logic [sams_pkg::COUNT_PORT_W-1:0]        odd_vertices,
    output logic                                     eulerian,
    output logic                                     semi_eulerian,
    output logic                                     bad_index
);

    import sams_pkg::*;

    localparam int CELLS = MAX_VERTICES * MAX_VERTICES;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int VIDX_W = $clog2(MAX_VERTICES);
    localparam int VX_W = (VIDX_W > VERTEX_IDX_W) ? VIDX_W : VERTEX_IDX_W;
    localparam int DEG_W = $clog2(MAX_VERTICES + 1);
    localparam int DX_W = (DEG_W > COUNT_PORT_W) ? DEG_W : COUNT_PORT_W;
    localparam int EDGE_W = $clog2(MAX_VERTICES * (MAX_VERTICES + 1) / 2 + 1);
    localparam int EX_W = (EDGE_W > EDGE_PORT_W) ? EDGE_W : EDGE_PORT_W;
    localparam int LIM_W = (DEG_W > COUNT_PORT_W) ? DEG_W : COUNT_PORT_W;
    localparam int WX_W = (WEIGHT_BITS > WEIGHT_PORT_W) ? WEIGHT_BITS : WEIGHT_PORT_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_UPD_A = 3'd3;
    localparam logic [2:0] S_UPD_B = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]               state_reg;
    logic [CELL_AW-1:0]       clr_cnt_reg;
    logic [COUNT_PORT_W-1:0]  vertex_count_reg;
    logic [EDGE_W-1:0]        edge_reg;
    logic [DEG_W-1:0]         odd_reg;

    logic                     write_reg;
    logic                     bad_reg;
    logic                     same_reg;
    logic                     chg_reg;
    logic [VIDX_W-1:0]        a_idx_reg;
    logic [VIDX_W-1:0]        b_idx_reg;
    logic [CELL_AW-1:0]       ab_reg;
    logic [CELL_AW-1:0]       ba_reg;
    logic [WEIGHT_BITS-1:0]   w_reg;
    logic [WEIGHT_BITS-1:0]   found_reg;
    logic [DEG_W-1:0]         deg_a_reg;
    logic [DEG_W-1:0]         deg_b_reg;

    logic                     result_valid_reg;
    logic [WEIGHT_PORT_W-1:0] found_weight_reg;
    logic [COUNT_PORT_W-1:0]  first_degree_reg;
    logic [COUNT_PORT_W-1:0]  second_degree_reg;
    logic [EDGE_PORT_W-1:0]   edge_total_reg;
    logic [COUNT_PORT_W-1:0]  odd_vertices_reg;
    logic                     eulerian_reg;
    logic                     semi_eulerian_reg;
    logic                     bad_index_reg;

    logic                     wt_we;
    logic [CELL_AW-1:0]       wt_waddr;
    logic [WEIGHT_BITS-1:0]   wt_wdata;
    logic                     wt_re;
    logic [WEIGHT_BITS-1:0]   wt_rdata;
    logic                     dg_we;
    logic [VIDX_W-1:0]        dg_waddr;
    logic [DEG_W-1:0]         dg_wdata;
    logic                     dg_re;
    logic [VIDX_W-1:0]        dg_raddr;
    logic [DEG_W-1:0]         dg_rdata;

    logic [LIM_W-1:0]         vc_ext;
    logic [LIM_W-1:0]         limit;
    logic                     bad_in;
    logic [VX_W-1:0]          a_ext;
    logic [VX_W-1:0]          b_ext;
    logic [CELL_AW-1:0]       a_cell;
    logic [CELL_AW-1:0]       b_cell;
    logic [WX_W-1:0]          w_ext;
    logic                     now_present;
    logic                     chg;
    logic [DEG_W-1:0]         deg_a_next;
    logic [DEG_W-1:0]         deg_b_src;
    logic                     bump_b;
    logic [DEG_W-1:0]         deg_b_next;
    logic [WX_W-1:0]          found_ext;
    logic [DX_W-1:0]          deg_a_ext;
    logic [DX_W-1:0]          deg_b_ext;
    logic [DX_W-1:0]          odd_ext;
    logic [EX_W-1:0]          edge_ext;
    logic                     out_free;

    function automatic logic [DEG_W-1:0] bump(input logic [DEG_W-1:0] d, input logic up);
        logic [DEG_W-1:0] r;
        begin
            r = d;
            if (up)
            begin
                r = d + DEG_W'(1);
            end
            else if (d != '0)
            begin
                r = d - DEG_W'(1);
            end
            return r;
        end
    endfunction

    function automatic logic [DEG_W-1:0] odd_after(input logic [DEG_W-1:0] odd,
                                                    input logic [DEG_W-1:0] deg);
        logic [DEG_W-1:0] r;
        begin
            r = odd;
            if (deg[0])
            begin
                r = odd + DEG_W'(1);
            end
            else if (odd != '0)
            begin
                r = odd - DEG_W'(1);
            end
            return r;
        end
    endfunction

    sams_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (CELLS)
    ) u_cells (
        .clk     (clk),
        .wr_en   (wt_we),
        .wr_addr (wt_waddr),
        .wr_data (wt_wdata),
        .rd_en   (wt_re),
        .rd_addr (ab_reg),
        .rd_data (wt_rdata)
    );

    sams_ram #(
        .WIDTH (DEG_W),
        .DEPTH (MAX_VERTICES)
    ) u_degrees (
        .clk     (clk),
        .wr_en   (dg_we),
        .wr_addr (dg_waddr),
        .wr_data (dg_wdata),
        .rd_en   (dg_re),
        .rd_addr (dg_raddr),
        .rd_data (dg_rdata)
    );

    assign vc_ext = LIM_W'(vertex_count_reg);
    assign limit = (vc_ext > LIM_W'(MAX_VERTICES)) ? LIM_W'(MAX_VERTICES) : vc_ext;
    assign bad_in = (LIM_W'(first_vertex) >= limit) || (LIM_W'(second_vertex) >= limit);
    assign a_ext = VX_W'(first_vertex);
    assign b_ext = VX_W'(second_vertex);
    assign a_cell = CELL_AW'(a_ext[VIDX_W-1:0]);
    assign b_cell = CELL_AW'(b_ext[VIDX_W-1:0]);
    assign w_ext = WX_W'($unsigned(weight));

    assign now_present = (w_reg != '0);
    assign chg = write_reg && ((wt_rdata != '0) != now_present);
    assign deg_a_next = chg ? bump(dg_rdata, now_present) : dg_rdata;
    assign deg_b_src = same_reg ? deg_a_reg : dg_rdata;
    assign bump_b = chg_reg && !same_reg;
    assign deg_b_next = bump_b ? bump(deg_b_src, now_present) : deg_b_src;

    assign out_free = !result_valid_reg || result_ready;

    always_comb
    begin
        wt_we = 1'b0;
        wt_waddr = ab_reg;
        wt_wdata = w_reg;
        wt_re = 1'b0;
        dg_we = 1'b0;
        dg_waddr = a_idx_reg;
        dg_wdata = deg_a_next;
        dg_re = 1'b0;
        dg_raddr = a_idx_reg;
        case (state_reg)
            S_CLEAR:
            begin
                wt_we = 1'b1;
                wt_waddr = clr_cnt_reg;
                wt_wdata = '0;
                dg_we = (clr_cnt_reg < CELL_AW'(MAX_VERTICES));
                dg_waddr = clr_cnt_reg[VIDX_W-1:0];
                dg_wdata = '0;
            end
            S_READ:
            begin
                wt_re = 1'b1;
                dg_re = 1'b1;
            end
            S_UPD_A:
            begin
                wt_we = write_reg;
                dg_we = chg;
                dg_re = !same_reg;
                dg_raddr = b_idx_reg;
            end
            S_UPD_B:
            begin
                wt_we = write_reg;
                wt_waddr = ba_reg;
                dg_we = bump_b;
                dg_waddr = b_idx_reg;
                dg_wdata = deg_b_next;
            end
            default:
            begin
                wt_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_cnt_reg <= '0;
            vertex_count_reg <= VERTEX_COUNT_RESET;
            edge_reg <= '0;
            odd_reg <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                vertex_count_reg <= vertex_count;
            end
            if ((state_reg == S_DONE) && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + CELL_AW'(1);
                    if (clr_cnt_reg == CELL_AW'(CELLS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        state_reg <= bad_in ? S_DONE : S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_UPD_A;
                end
                S_UPD_A:
                begin
                    if (chg)
                    begin
                        odd_reg <= odd_after(odd_reg, deg_a_next);
                        if (now_present)
                        begin
                            edge_reg <= edge_reg + EDGE_W'(1);
                        end
                        else if (edge_reg != '0)
                        begin
                            edge_reg <= edge_reg - EDGE_W'(1);
                        end
                    end
                    state_reg <= S_UPD_B;
                end
                S_UPD_B:
                begin
                    if (bump_b)
                    begin
                        odd_reg <= odd_after(odd_reg, deg_b_next);
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                write_reg <= (op == OP_WRITE);
                bad_reg <= bad_in;
                same_reg <= (first_vertex == second_vertex);
                a_idx_reg <= a_ext[VIDX_W-1:0];
                b_idx_reg <= b_ext[VIDX_W-1:0];
                ab_reg <= CELL_AW'(a_cell * CELL_AW'(MAX_VERTICES) + b_cell);
                ba_reg <= CELL_AW'(b_cell * CELL_AW'(MAX_VERTICES) + a_cell);
                w_reg <= w_ext[WEIGHT_BITS-1:0];
                found_reg <= '0;
                deg_a_reg <= '0;
                deg_b_reg <= '0;
            end
            S_UPD_A:
            begin
                found_reg <= wt_rdata;
                deg_a_reg <= deg_a_next;
                chg_reg <= chg;
            end
            S_UPD_B:
            begin
                deg_b_reg <= deg_b_next;
            end
            default:
            begin
                chg_reg <= chg_reg;
            end
        endcase
    end

    assign found_ext = WX_W'($signed(found_reg));
    assign deg_a_ext = DX_W'(deg_a_reg);
    assign deg_b_ext = DX_W'(deg_b_reg);
    assign odd_ext = DX_W'(odd_reg);
    assign edge_ext = EX_W'(edge_reg);

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            found_weight_reg <= found_ext[WEIGHT_PORT_W-1:0];
            first_degree_reg <= deg_a_ext[COUNT_PORT_W-1:0];
            second_degree_reg <= deg_b_ext[COUNT_PORT_W-1:0];
            edge_total_reg <= edge_ext[EDGE_PORT_W-1:0];
            odd_vertices_reg <= odd_ext[COUNT_PORT_W-1:0];
            eulerian_reg <= (odd_reg == '0);
            semi_eulerian_reg <= (odd_reg == '0) || (odd_reg == DEG_W'(2));
            bad_index_reg <= bad_reg;
        end
    end

    assign cfg_ready = 1'b1;
    assign item_ready = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign found_weight = found_weight_reg;
    assign first_degree = first_degree_reg;
    assign second_degree = second_degree_reg;
    assign edge_total = edge_total_reg;
    assign odd_vertices = odd_vertices_reg;
    assign eulerian = eulerian_reg;
    assign semi_eulerian = semi_eulerian_reg;
    assign bad_index = bad_index_reg;

endmodule

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sams_pkg::*;

    localparam int VERTICES = 64;
    localparam int STALL_CYCLES = 400;

    typedef struct packed {
        logic signed [WEIGHT_PORT_W-1:0] found;
        logic [COUNT_PORT_W-1:0]         deg_a;
        logic [COUNT_PORT_W-1:0]         deg_b;
        logic [EDGE_PORT_W-1:0]          edges;
        logic [COUNT_PORT_W-1:0]         odd;
        logic                            euler;
        logic                            semi;
        logic                            bad;
    } edge_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [COUNT_PORT_W-1:0] vertex_count = '0;
    logic item_valid = 1'b0;
    logic item_ready;
    logic op = OP_WRITE;
    logic [VERTEX_IDX_W-1:0] first_vertex = '0;
    logic [VERTEX_IDX_W-1:0] second_vertex = '0;
    logic signed [WEIGHT_PORT_W-1:0] weight = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    logic signed [WEIGHT_PORT_W-1:0] found_weight;
    logic [COUNT_PORT_W-1:0] first_degree;
    logic [COUNT_PORT_W-1:0] second_degree;
    logic [EDGE_PORT_W-1:0] edge_total;
    logic [COUNT_PORT_W-1:0] odd_vertices;
    logic eulerian;
    logic semi_eulerian;
    logic bad_index;

    logic signed [WEIGHT_PORT_W-1:0] shadow_cells [VERTICES][VERTICES];
    logic [COUNT_PORT_W-1:0] shadow_degree [VERTICES];
    logic [EDGE_PORT_W-1:0] shadow_edges = '0;
    logic [COUNT_PORT_W-1:0] shadow_odd = '0;
    logic [COUNT_PORT_W-1:0] shadow_vcount = VERTEX_COUNT_RESET;

    edge_report_t pending_reports [$];
    int mismatches = 0;
    int sender_gap_pct = 0;
    int reader_stall_pct = 0;
    logic stall_trigger = 1'b0;
    logic stall_seen = 1'b0;
    int stall_left = 0;

    symmetric_adjacency_matrix_store dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .vertex_count (vertex_count),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .op           (op),
        .first_vertex (first_vertex),
        .second_vertex(second_vertex),
        .weight       (weight),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .found_weight (found_weight),
        .first_degree (first_degree),
        .second_degree(second_degree),
        .edge_total   (edge_total),
        .odd_vertices (odd_vertices),
        .eulerian     (eulerian),
        .semi_eulerian(semi_eulerian),
        .bad_index    (bad_index)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < VERTICES; i++)
        begin
            shadow_degree[i] = '0;
            for (int j = 0; j < VERTICES; j++)
                shadow_cells[i][j] = '0;
        end
    end

    function automatic void bump_degree(int v, logic up);
        if (up)
            shadow_degree[v] = shadow_degree[v] + 1'b1;
        else if (shadow_degree[v] != 0)
            shadow_degree[v] = shadow_degree[v] - 1'b1;
        if (shadow_degree[v][0])
            shadow_odd = shadow_odd + 1'b1;
        else if (shadow_odd != 0)
            shadow_odd = shadow_odd - 1'b1;
    endfunction

    function automatic edge_report_t apply_edge_item(logic item_op, int a, int b,
                                                     logic signed [WEIGHT_PORT_W-1:0] w);
        edge_report_t r;
        int limit;
        logic was_set;
        logic is_set;
        r = '{default: '0};
        limit = (shadow_vcount > VERTICES) ? VERTICES : int'(shadow_vcount);
        r.bad = (a >= limit) || (b >= limit);
        if (!r.bad)
        begin
            r.found = shadow_cells[a][b];
            if (item_op == OP_WRITE)
            begin
                was_set = shadow_cells[a][b] != 0;
                is_set = w != 0;
                shadow_cells[a][b] = w;
                shadow_cells[b][a] = w;
                if (was_set != is_set)
                begin
                    if (is_set)
                        shadow_edges = shadow_edges + 1'b1;
                    else if (shadow_edges != 0)
                        shadow_edges = shadow_edges - 1'b1;
                    bump_degree(a, is_set);
                    if (b != a)
                        bump_degree(b, is_set);
                end
            end
            r.deg_a = shadow_degree[a];
            r.deg_b = shadow_degree[b];
        end
        r.edges = shadow_edges;
        r.odd = shadow_odd;
        r.euler = shadow_odd == 0;
        r.semi = (shadow_odd == 0) || (shadow_odd == 2);
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        edge_report_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("result transfer with no item outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("found_weight", want.found, found_weight);
                check_field("first_degree", want.deg_a, first_degree);
                check_field("second_degree", want.deg_b, second_degree);
                check_field("edge_total", want.edges, edge_total);
                check_field("odd_vertices", want.odd, odd_vertices);
                check_field("eulerian", want.euler, eulerian);
                check_field("semi_eulerian", want.semi, semi_eulerian);
                check_field("bad_index", want.bad, bad_index);
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_trigger != stall_seen)
        begin
            stall_seen <= stall_trigger;
            stall_left <= STALL_CYCLES;
            result_ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(0, 99) >= reader_stall_pct);
    end

    task automatic send_item(logic item_op, int a, int b, logic signed [WEIGHT_PORT_W-1:0] w);
        int gap;
        edge_report_t report;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < sender_gap_pct)
            gap++;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        op <= item_op;
        first_vertex <= a[VERTEX_IDX_W-1:0];
        second_vertex <= b[VERTEX_IDX_W-1:0];
        weight <= w;
        do
            @(posedge clk);
        while (!item_ready);
        report = apply_edge_item(item_op, a, b, w);
        pending_reports.insert(pending_reports.size(), report);
    endtask

    task automatic wait_results_drained();
        item_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_vertex_count(int value);
        wait_results_drained();
        cfg_valid <= 1'b1;
        vertex_count <= value[COUNT_PORT_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_vcount = value[COUNT_PORT_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(int sender_pct, int reader_pct);
        sender_gap_pct = sender_pct;
        reader_stall_pct <= reader_pct;
    endtask

    task automatic test_clear_after_reset();
        write_vertex_count(127);
        send_item(OP_READ, 0, 0, 16'sh1234);
        send_item(OP_READ, 63, 63, 16'sh0000);
    endtask

    task automatic test_weight_extremes();
        send_item(OP_WRITE, 0, 63, 16'sh7FFF);
        send_item(OP_WRITE, 63, 0, 16'sh8000);
        send_item(OP_READ, 0, 63, 16'sh0000);
        send_item(OP_WRITE, 0, 63, 16'shFFFF);
        send_item(OP_WRITE, 0, 63, 16'sh0000);
        send_item(OP_WRITE, 1, 2, 16'sh0000);
        send_item(OP_WRITE, 3, 4, 16'sh0001);
    endtask

    task automatic test_self_loop();
        send_item(OP_WRITE, 5, 5, 16'sh5555);
        send_item(OP_READ, 5, 5, 16'sh0000);
        send_item(OP_WRITE, 5, 6, 16'sh2AAA);
        send_item(OP_WRITE, 5, 5, 16'sh0000);
    endtask

    task automatic test_vertex_limits();
        write_vertex_count(1);
        send_item(OP_WRITE, 0, 0, 16'sh0007);
        send_item(OP_WRITE, 0, 1, 16'sh0009);
        send_item(OP_READ, 1, 0, 16'sh0000);
        write_vertex_count(0);
        send_item(OP_READ, 0, 0, 16'sh0000);
        write_vertex_count(40);
        send_item(OP_WRITE, 39, 3, 16'sh0064);
        send_item(OP_WRITE, 3, 40, 16'sh0005);
        send_item(OP_READ, 63, 0, 16'sh0000);
        write_vertex_count(64);
        send_item(OP_READ, 3, 39, 16'sh0000);
    endtask

    task automatic test_random_traffic(int count, int window);
        int limit;
        int pool;
        int a;
        int b;
        logic item_op;
        logic signed [WEIGHT_PORT_W-1:0] w;
        logic signed [WEIGHT_PORT_W-1:0] corner [4];
        corner = '{16'sh7FFF, 16'sh8000, 16'shFFFF, 16'sh0001};
        limit = (shadow_vcount > VERTICES) ? VERTICES : int'(shadow_vcount);
        if (limit == 0)
            limit = VERTICES;
        pool = (limit < window) ? limit : window;
        repeat (count)
        begin
            item_op = ($urandom_range(0, 99) < 25) ? OP_READ : OP_WRITE;
            if ($urandom_range(0, 99) < 65)
            begin
                a = $urandom_range(0, pool - 1);
                b = $urandom_range(0, pool - 1);
            end
            else
            begin
                a = $urandom_range(0, VERTICES - 1);
                b = $urandom_range(0, VERTICES - 1);
            end
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6: w = '0;
                7, 8: w = corner[$urandom_range(0, 3)];
                default: w = WEIGHT_PORT_W'($urandom);
            endcase
            send_item(item_op, a, b, w);
        end
    endtask

    task automatic test_dense_row();
        int hub;
        int order [VERTICES];
        int pick;
        int swap;
        hub = $urandom_range(0, VERTICES - 1);
        for (int i = 0; i < VERTICES; i++)
            order[i] = i;
        for (int i = VERTICES - 1; i > 0; i--)
        begin
            pick = $urandom_range(0, i);
            swap = order[i];
            order[i] = order[pick];
            order[pick] = swap;
        end
        for (int i = 0; i < VERTICES; i++)
        begin
            if ($urandom_range(0, 1) == 0)
                send_item(OP_WRITE, hub, order[i], WEIGHT_PORT_W'($urandom_range(1, 65535)));
            else
                send_item(OP_WRITE, order[i], hub, WEIGHT_PORT_W'($urandom_range(1, 65535)));
        end
        send_item(OP_READ, hub, hub, 16'sh0000);
    endtask

    task automatic test_backpressure();
        stall_trigger <= ~stall_trigger;
        test_random_traffic(40, 8);
        wait_results_drained();
        test_random_traffic(10, 8);
    endtask

    initial
    begin
        set_idling(38, 56);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_clear_after_reset();
        test_weight_extremes();
        test_self_loop();
        test_vertex_limits();

        test_random_traffic(350, 8);

        wait_results_drained();
        set_idling(56, 38);
        write_vertex_count(17);
        test_random_traffic(70, 12);
        write_vertex_count(2);
        test_random_traffic(70, 12);
        write_vertex_count(0);
        test_random_traffic(30, 12);
        write_vertex_count(127);
        test_random_traffic(70, 12);
        write_vertex_count($urandom_range(1, 64));
        test_random_traffic(70, 12);
        write_vertex_count(64);

        wait_results_drained();
        set_idling(0, 0);
        test_dense_row();
        test_backpressure();
        test_random_traffic(250, 16);

        wait_results_drained();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
